### hw/rtl/matrix4_vector_transform_macros.svh
// Assertion macros for the 4x4 matrix-vector transform.
// Expects signals named clock and reset in the module that uses them.
`ifndef MATRIX4_VECTOR_TRANSFORM_MACROS_SVH
`define MATRIX4_VECTOR_TRANSFORM_MACROS_SVH

// same-cycle implication, disabled during reset
`define M4VT_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("m4vt assertion failed");

// next-cycle implication, disabled during reset
`define M4VT_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("m4vt assertion failed");

`endif

### hw/rtl/m4vt_pkg.sv
// Shared types and constants for the 4x4 matrix-vector transform.
// No dependencies; used by the lane, merge and top-level files.
package m4vt_pkg;

   localparam int NUM_LANES = 4;
   localparam int NUM_COLS  = 4;
   localparam int NUM_PAIRS = 8;
   localparam int ELEM_W    = 32;
   localparam int PAIR_W    = 64;
   localparam int PROD_W    = 64;
   localparam int SUM_W     = 66;
   localparam int FRAC_W    = 16;
   localparam int INDEX_W   = 3;

   localparam logic [PAIR_W-1:0] PAIR_RESET [NUM_PAIRS] = '{
      64'h0000_0000_0001_0000,
      64'h0000_0000_0000_0000,
      64'h0001_0000_0000_0000,
      64'h0000_0000_0000_0000,
      64'h0000_0000_0000_0000,
      64'h0000_0000_0001_0000,
      64'h0000_0000_0000_0000,
      64'h0001_0000_0000_0000
   };

   typedef logic signed [ELEM_W-1:0] m4vt_elem_type;
   typedef logic [NUM_COLS-1:0][ELEM_W-1:0] m4vt_vec_type;
   typedef logic [NUM_LANES-1:0][SUM_W-1:0] m4vt_sum_vec_type;

   typedef struct packed {
      logic signed [ELEM_W-1:0] vec_x;
      logic signed [ELEM_W-1:0] vec_y;
      logic signed [ELEM_W-1:0] vec_z;
      logic signed [ELEM_W-1:0] vec_w;
      logic                     is_flat;
   } m4vt_req_type;

   typedef struct packed {
      logic signed [ELEM_W-1:0] out_x;
      logic signed [ELEM_W-1:0] out_y;
      logic signed [ELEM_W-1:0] out_z;
      logic signed [ELEM_W-1:0] out_w;
      logic                     rejected;
   } m4vt_rsp_type;

   typedef struct packed {
      logic valid;
      logic flat;
   } m4vt_ctl_type;

endpackage

### hw/rtl/m4vt_lane.sv
// One row lane: four 32x32 signed products, then their exact 66-bit sum.
// Depends on m4vt_pkg.
module m4vt_lane (
   input  logic                  clock,
   input  m4vt_pkg::m4vt_vec_type row_i,
   input  m4vt_pkg::m4vt_vec_type vec_i,
   output logic [m4vt_pkg::SUM_W-1:0] sum_o
);

   logic signed [m4vt_pkg::PROD_W-1:0] prod_in [m4vt_pkg::NUM_COLS];
   logic signed [m4vt_pkg::PROD_W-1:0] prod_ff [m4vt_pkg::NUM_COLS];
   logic signed [m4vt_pkg::SUM_W-1:0]  sum_in;
   logic signed [m4vt_pkg::SUM_W-1:0]  sum_ff;

   always_comb begin
      for (int k = 0; k < m4vt_pkg::NUM_COLS; k++) begin
         prod_in[k] = $signed(row_i[k]) * $signed(vec_i[k]);
      end
   end

   always_comb begin
      sum_in = '0;
      for (int k = 0; k < m4vt_pkg::NUM_COLS; k++) begin
         sum_in = sum_in + m4vt_pkg::SUM_W'(prod_ff[k]);
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      sum_ff  <= sum_in;
   end

   assign sum_o = sum_ff;

endmodule

### hw/rtl/m4vt_merge.sv
// Merge stage: shift and saturate each lane sum, apply reject, register the beat.
// Depends on m4vt_pkg.
module m4vt_merge (
   input  logic                      clock,
   input  logic                      reset,
   input  m4vt_pkg::m4vt_ctl_type     ctl_i,
   input  m4vt_pkg::m4vt_sum_vec_type sum_i,
   output logic                      rsp_valid_o,
   output m4vt_pkg::m4vt_rsp_type     rsp_data_o
);

   localparam int SHIFT_W = m4vt_pkg::SUM_W - m4vt_pkg::FRAC_W;
   localparam int TOP_W   = SHIFT_W - m4vt_pkg::ELEM_W + 1;

   logic [m4vt_pkg::ELEM_W-1:0] elem_sat [m4vt_pkg::NUM_LANES];
   logic                        rsp_valid_ff;
   m4vt_pkg::m4vt_rsp_type       rsp_data_in;
   m4vt_pkg::m4vt_rsp_type       rsp_data_ff;

   always_comb begin
      for (int l = 0; l < m4vt_pkg::NUM_LANES; l++) begin
         logic [SHIFT_W-1:0] shifted;
         logic [TOP_W-1:0]   top;
         shifted = sum_i[l][m4vt_pkg::SUM_W-1:m4vt_pkg::FRAC_W];
         top     = shifted[SHIFT_W-1:m4vt_pkg::ELEM_W-1];
         if ((&top) || !(|top)) begin
            elem_sat[l] = shifted[m4vt_pkg::ELEM_W-1:0];
         end else if (top[TOP_W-1]) begin
            elem_sat[l] = {1'b1, {(m4vt_pkg::ELEM_W-1){1'b0}}};
         end else begin
            elem_sat[l] = {1'b0, {(m4vt_pkg::ELEM_W-1){1'b1}}};
         end
         if (ctl_i.flat) begin
            elem_sat[l] = '0;
         end
      end
   end

   always_comb begin
      rsp_data_in.out_x    = elem_sat[0];
      rsp_data_in.out_y    = elem_sat[1];
      rsp_data_in.out_z    = elem_sat[2];
      rsp_data_in.out_w    = elem_sat[3];
      rsp_data_in.rejected = ctl_i.flat;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= ctl_i.valid;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid_o = rsp_valid_ff;
   assign rsp_data_o  = rsp_data_ff;

endmodule

### hw/rtl/matrix4_vector_transform.sv
// Top level of the 4x4 matrix-vector transform: matrix registers, four row
// lanes and the merge stage. Depends on m4vt_pkg, m4vt_lane, m4vt_merge.
//
//   channel   ports                                  handshake
//   request   start, busy, req_data                  start && !busy
//   response  rsp_valid, rsp_data                    rsp_valid, one cycle
//   csr       csr_write, csr_index, csr_wdata        csr_write
//
// One vector per cycle while busy is low; each result passes the multiply register and
// row-sum register in each lane, then the merge register.
// busy is registered: set during reset and cleared once reset is released; otherwise beats flow every cycle.
// Reset is synchronous and loads the identity matrix.
// The receiver cannot stall, so nothing is ever held back.
`include "matrix4_vector_transform_macros.svh"

module matrix4_vector_transform (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  m4vt_pkg::m4vt_req_type             req_data,
   output logic                              rsp_valid,
   output m4vt_pkg::m4vt_rsp_type             rsp_data,
   input  logic                              csr_write,
   input  logic [m4vt_pkg::INDEX_W-1:0]       csr_index,
   input  logic [m4vt_pkg::PAIR_W-1:0]        csr_wdata
);

   logic [m4vt_pkg::PAIR_W-1:0] csr_pair_ff [m4vt_pkg::NUM_PAIRS];
   logic                        busy_ff;
   logic                        accept;
   m4vt_pkg::m4vt_ctl_type       ctl_s1_in;
   m4vt_pkg::m4vt_ctl_type       ctl_s1_ff;
   m4vt_pkg::m4vt_ctl_type       ctl_s2_ff;
   m4vt_pkg::m4vt_vec_type       vec;
   m4vt_pkg::m4vt_vec_type       rows [m4vt_pkg::NUM_LANES];
   m4vt_pkg::m4vt_sum_vec_type   sums;

   assign accept = start && !busy_ff;
   assign busy   = busy_ff;

   assign vec[0] = req_data.vec_x;
   assign vec[1] = req_data.vec_y;
   assign vec[2] = req_data.vec_z;
   assign vec[3] = req_data.vec_w;

   always_comb begin
      ctl_s1_in.valid = accept;
      ctl_s1_in.flat  = req_data.is_flat;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b1;
         ctl_s1_ff   <= '0;
         ctl_s2_ff   <= '0;
         csr_pair_ff <= m4vt_pkg::PAIR_RESET;
      end else begin
         busy_ff   <= 1'b0;
         ctl_s1_ff <= ctl_s1_in;
         ctl_s2_ff <= ctl_s1_ff;
         if (csr_write) begin
            csr_pair_ff[csr_index] <= csr_wdata;
         end
      end
   end

   for (genvar r = 0; r < m4vt_pkg::NUM_LANES; r++) begin : g_lane
      for (genvar c = 0; c < m4vt_pkg::NUM_COLS; c++) begin : g_col
         assign rows[r][c] =
            csr_pair_ff[r * 2 + c / 2][(c % 2) * m4vt_pkg::ELEM_W +: m4vt_pkg::ELEM_W];
      end

      m4vt_lane u_lane (
         .clock (clock),
         .row_i (rows[r]),
         .vec_i (vec),
         .sum_o (sums[r])
      );
   end

   m4vt_merge u_merge (
      .clock       (clock),
      .reset       (reset),
      .ctl_i       (ctl_s2_ff),
      .sum_i       (sums),
      .rsp_valid_o (rsp_valid),
      .rsp_data_o  (rsp_data)
   );

   `M4VT_ASSERT_IMPL(a_beat_latency, start && !busy, ##3 rsp_valid)
   `M4VT_ASSERT_IMPL(a_no_spurious_rsp, rsp_valid, $past(start && !busy, 3))
   `M4VT_ASSERT_IMPL(a_reject_zero, rsp_valid && rsp_data.rejected,
      rsp_data.out_x == '0 && rsp_data.out_y == '0 && rsp_data.out_z == '0 && rsp_data.out_w == '0)
   `M4VT_ASSERT_NEXT(a_busy_only_after_reset, !busy, !busy)

endmodule
